// ===== design/swt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swt_pkg
// Types and codes shared by the send-window tracker modules.
// ----------------------------------------------------------------------------
package swt_pkg;

    localparam logic [1:0] MODE_RECORD = 2'd0;
    localparam logic [1:0] MODE_ACK    = 2'd1;
    localparam logic [1:0] MODE_REJECT = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [1:0] ST_EMPTY    = 2'd0;
    localparam logic [1:0] ST_INFLIGHT = 2'd1;
    localparam logic [1:0] ST_ACKED    = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    localparam logic [1:0] RC_OK      = 2'd0;
    localparam logic [1:0] RC_BLOCKED = 2'd1;
    localparam logic [1:0] RC_FULL    = 2'd2;

    localparam logic [4:0] WINDOW_RESET = 5'd7;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] seq;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    typedef struct packed {
        t_entry entry;
        logic   hit;
    } t_head_res;

endpackage
`default_nettype wire

// ===== design/ax25_send_window_tracker_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ax25_send_window_tracker_top
// Send-window tracker: a chain of table cells that rotates once through a
// scan stage for each acknowledge or reject, plus running totals.
// ----------------------------------------------------------------------------
// Record and clear: the beat moves to the done state, and its result is then loaded
// into the output registers. Acknowledge and reject: the chain first rotates once
// through the scan stage. No new input beat is taken until the result is loaded.
// A new input beat is taken while a finished result still waits downstream.
// Reset empties the table, zeroes all totals and sets the window limit to 7.
module ax25_send_window_tracker_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [4:0]  i_cfg_window_limit,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_mode,
    input  wire  [2:0]  i_seq_sent,
    input  wire  [2:0]  i_seq_recv,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_result_code,
    output logic [4:0]  o_changed_count,
    output logic [4:0]  o_in_flight_now,
    output logic [31:0] o_recorded_total,
    output logic [31:0] o_acked_total,
    output logic [31:0] o_rejected_total,
    output logic [31:0] o_blocked_total,
    output logic [4:0]  o_peak_in_flight
);
    import swt_pkg::*;

    localparam int CL = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (CL > 5) ? CL : 5;
    localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]    r_state,         n_state;
    logic [SW-1:0] r_scan_cnt,      n_scan_cnt;
    logic [1:0]    r_mode,          n_mode;
    logic [2:0]    r_seq_recv,      n_seq_recv;
    logic [4:0]    r_window_limit;
    logic [CW-1:0] r_entry_count,   n_entry_count;
    logic [CW-1:0] r_flight_cnt,    n_flight_cnt;
    logic [CW-1:0] r_peak,          n_peak;
    logic [CW-1:0] r_changed,       n_changed;
    logic [1:0]    r_code,          n_code;
    logic [31:0]   r_recorded,      n_recorded;
    logic [31:0]   r_acked,         n_acked;
    logic [31:0]   r_rejected,      n_rejected;
    logic [31:0]   r_blocked,       n_blocked;
    logic          r_out_valid,     n_out_valid;
    logic          w_load_out;
    logic          w_in_acc;
    logic [32:0]   w_sum_acked;
    logic [32:0]   w_sum_rejected;
    logic [32:0]   w_sum_recorded;
    logic [32:0]   w_sum_blocked;
    logic [CW-1:0] w_flight_inc;

    t_cell_ctrl    w_ctrl;
    t_head_res     w_head;
    t_entry        w_chain [TABLE_DEPTH+1];

    assign w_chain[0] = (r_state == S_SCAN) ? w_head.entry : t_entry'({ST_INFLIGHT, i_seq_sent});

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        swt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_entry (w_chain[g]),
            .o_entry (w_chain[g+1])
        );
    end

    swt_head u_head (
        .i_mode     (r_mode),
        .i_seq_recv (r_seq_recv),
        .i_entry    (w_chain[TABLE_DEPTH]),
        .o_res      (w_head)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_limit <= WINDOW_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window_limit <= i_cfg_window_limit;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_scan_cnt    = r_scan_cnt;
        n_mode        = r_mode;
        n_seq_recv    = r_seq_recv;
        n_entry_count = r_entry_count;
        n_flight_cnt  = r_flight_cnt;
        n_peak        = r_peak;
        n_changed     = r_changed;
        n_code        = r_code;
        n_recorded    = r_recorded;
        n_acked       = r_acked;
        n_rejected    = r_rejected;
        n_blocked     = r_blocked;
        n_out_valid   = r_out_valid;
        w_load_out    = 1'b0;
        w_ctrl.shift  = 1'b0;
        w_ctrl.clear  = 1'b0;

        w_flight_inc   = r_flight_cnt + CW'(1);
        w_sum_recorded = {1'b0, r_recorded} + 33'd1;
        w_sum_blocked  = {1'b0, r_blocked} + 33'd1;
        w_sum_acked    = {1'b0, r_acked} + 33'(r_changed);
        w_sum_rejected = {1'b0, r_rejected} + 33'(r_changed);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_mode     = i_mode;
                    n_seq_recv = i_seq_recv;
                    n_changed  = '0;
                    n_code     = RC_OK;
                    n_state    = S_DONE;
                    case (i_mode)
                        MODE_RECORD: begin
                            if (r_flight_cnt >= CW'(r_window_limit)) begin
                                n_code    = RC_BLOCKED;
                                n_blocked = w_sum_blocked[32] ? '1 : w_sum_blocked[31:0];
                            end else if (r_entry_count >= CW'(TABLE_DEPTH)) begin
                                n_code = RC_FULL;
                            end else begin
                                w_ctrl.shift  = 1'b1;
                                n_entry_count = r_entry_count + CW'(1);
                                n_flight_cnt  = w_flight_inc;
                                n_recorded    = w_sum_recorded[32] ? '1
                                                                   : w_sum_recorded[31:0];
                                if (w_flight_inc > r_peak) begin
                                    n_peak = w_flight_inc;
                                end
                            end
                        end
                        MODE_ACK, MODE_REJECT: begin
                            n_scan_cnt = SW'(TABLE_DEPTH - 1);
                            n_state    = S_SCAN;
                        end
                        default: begin
                            w_ctrl.clear  = 1'b1;
                            n_entry_count = '0;
                            n_flight_cnt  = '0;
                            n_peak        = '0;
                            n_recorded    = '0;
                            n_acked       = '0;
                            n_rejected    = '0;
                            n_blocked     = '0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                w_ctrl.shift = 1'b1;
                n_changed    = r_changed + CW'(w_head.hit);
                n_scan_cnt   = r_scan_cnt - SW'(1);
                if (r_scan_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_mode == MODE_ACK) begin
                        n_acked = w_sum_acked[32] ? '1 : w_sum_acked[31:0];
                    end
                    if (r_mode == MODE_REJECT) begin
                        n_rejected = w_sum_rejected[32] ? '1 : w_sum_rejected[31:0];
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (r_state == S_SCAN && r_scan_cnt == '0) begin
            n_flight_cnt = r_flight_cnt - n_changed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= '0;
            r_flight_cnt  <= '0;
            r_peak        <= '0;
            r_recorded    <= '0;
            r_acked       <= '0;
            r_rejected    <= '0;
            r_blocked     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_entry_count <= n_entry_count;
            r_flight_cnt  <= n_flight_cnt;
            r_peak        <= n_peak;
            r_recorded    <= n_recorded;
            r_acked       <= n_acked;
            r_rejected    <= n_rejected;
            r_blocked     <= n_blocked;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_cnt <= n_scan_cnt;
        r_mode     <= n_mode;
        r_seq_recv <= n_seq_recv;
        r_changed  <= n_changed;
        r_code     <= n_code;
    end

    // Totals from an acknowledge or reject are folded in as the result is loaded.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            o_result_code    <= r_code;
            o_changed_count  <= r_changed[4:0];
            o_in_flight_now  <= r_flight_cnt[4:0];
            o_recorded_total <= r_recorded;
            o_peak_in_flight <= r_peak[4:0];
            o_blocked_total  <= r_blocked;
            if (r_mode == MODE_ACK) begin
                o_acked_total <= w_sum_acked[32] ? '1 : w_sum_acked[31:0];
            end else begin
                o_acked_total <= r_acked;
            end
            if (r_mode == MODE_REJECT) begin
                o_rejected_total <= w_sum_rejected[32] ? '1 : w_sum_rejected[31:0];
            end else begin
                o_rejected_total <= r_rejected;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/swt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swt_cell
// One table slot: holds a status and a sequence number and takes its
// neighbor's entry whenever the chain shifts.
// ----------------------------------------------------------------------------
module swt_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  swt_pkg::t_cell_ctrl  i_ctrl,
    input  swt_pkg::t_entry      i_entry,
    output swt_pkg::t_entry      o_entry
);
    import swt_pkg::*;

    logic [1:0] r_status;
    logic [2:0] r_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_status <= ST_EMPTY;
        end else if (i_ctrl.shift) begin
            r_status <= i_entry.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_seq <= i_entry.seq;
        end
    end

    assign o_entry.status = r_status;
    assign o_entry.seq    = r_seq;

endmodule
`default_nettype wire

// ===== design/swt_head.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swt_head
// Scan stage at the end of the chain: applies an acknowledge or reject to
// the entry leaving the last cell before it re-enters the first one.
// ----------------------------------------------------------------------------
module swt_head (
    input  wire                 [1:0] i_mode,
    input  wire                 [2:0] i_seq_recv,
    input  swt_pkg::t_entry           i_entry,
    output swt_pkg::t_head_res        o_res
);
    import swt_pkg::*;

    logic       w_inflight;
    logic       w_match;
    logic [2:0] w_dist;

    always_comb begin
        w_inflight = (i_entry.status == ST_INFLIGHT);
        w_dist     = i_seq_recv - i_entry.seq;
        case (i_mode)
            MODE_ACK:    w_match = (w_dist != 3'd0);
            MODE_REJECT: w_match = (w_dist == 3'd0);
            default:     w_match = 1'b0;
        endcase
        o_res.hit       = w_inflight && w_match;
        o_res.entry.seq = i_entry.seq;
        if (o_res.hit) begin
            o_res.entry.status = (i_mode == MODE_ACK) ? ST_ACKED : ST_REJECTED;
        end else begin
            o_res.entry.status = i_entry.status;
        end
    end

endmodule
`default_nettype wire
